/* hw/rtl/sbs_pkg.sv */
package sbs_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int KEY_W         = 32;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int COUNT_W       = IDX_W + 1;
  localparam int SUM_W         = COUNT_W + 1;
  localparam int PROBE_W       = $clog2(IDX_W + 2);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } sbs_op_t;

  typedef struct packed {
    logic start;
    logic write;
    logic probe;
    logic load_out;
  } sbs_cmd_t;

  typedef struct packed {
    logic more;
    logic match;
  } sbs_sts_t;

endpackage

/* hw/rtl/sbs_ctrl.sv */
module sbs_ctrl import sbs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [0:0]         opcode,
  input  logic               out_stall,
  input  sbs_sts_t           sts,
  output sbs_cmd_t           cmd,
  output logic               in_stall,
  output logic               out_valid
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = sts.more ? S_PROBE : S_DONE;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.match || !sts.more) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

/* hw/rtl/sbs_datapath.sv */
module sbs_datapath import sbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [COUNT_W-1:0]       cfg_data,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [KEY_W-1:0]  record_key,
  input  logic [PAYLOAD_WIDTH-1:0] record_payload,
  input  sbs_cmd_t                 cmd,
  output sbs_sts_t                 sts,
  output logic                     found,
  output logic [IDX_W-1:0]         position,
  output logic [PAYLOAD_WIDTH-1:0] payload_out,
  output logic [PROBE_W-1:0]       probe_count
);

  logic signed [KEY_W-1:0]  key_mem [TABLE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [TABLE_DEPTH];

  logic [COUNT_W-1:0]       entry_count;
  logic [COUNT_W-1:0]       count_clamp;
  logic [COUNT_W-1:0]       lo;
  logic [COUNT_W-1:0]       hi_p1;
  logic [COUNT_W-1:0]       lo_next;
  logic [COUNT_W-1:0]       hi_p1_next;
  logic [SUM_W-1:0]         mid_sum;
  logic [IDX_W-1:0]         mid;
  logic [IDX_W-1:0]         mid_next;
  logic signed [KEY_W-1:0]  key;
  logic signed [KEY_W-1:0]  rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic                     rd_lt;
  logic [PROBE_W-1:0]       probes;
  logic                     hit;
  logic [IDX_W-1:0]         hit_pos;
  logic [PAYLOAD_WIDTH-1:0] hit_pay;

  assign count_clamp = (entry_count > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
                                                             : entry_count;
  assign rd_lt = rd_key < key;

  always_comb begin
    lo_next    = lo;
    hi_p1_next = hi_p1;
    if (cmd.start) begin
      lo_next    = '0;
      hi_p1_next = count_clamp;
    end else if (cmd.probe) begin
      if (rd_lt) begin
        lo_next = {1'b0, mid} + COUNT_W'(1);
      end else begin
        hi_p1_next = {1'b0, mid};
      end
    end
    mid_sum   = {1'b0, lo_next} + {1'b0, hi_p1_next} - SUM_W'(1);
    mid_next  = mid_sum[IDX_W:1];
    sts.more  = lo_next < hi_p1_next;
    sts.match = (rd_key == key);
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      key_mem[entry_index] <= record_key;
      pay_mem[entry_index] <= record_payload;
    end
    rd_key <= key_mem[mid_next];
    rd_pay <= pay_mem[mid_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi_p1 <= hi_p1_next;
    mid   <= mid_next;
    if (cmd.start) begin
      key     <= record_key;
      probes  <= '0;
      hit     <= 1'b0;
      hit_pos <= '0;
      hit_pay <= '0;
    end
    if (cmd.probe) begin
      probes <= probes + PROBE_W'(1);
      if (sts.match) begin
        hit     <= 1'b1;
        hit_pos <= mid;
        hit_pay <= rd_pay;
      end
    end
    if (cmd.load_out) begin
      found       <= hit;
      position    <= hit_pos;
      payload_out <= hit_pay;
      probe_count <= probes;
    end
  end

endmodule

/* hw/rtl/sorted_table_binary_search.sv */
// Sorted table binary search.
// Input channel (in_valid / in_stall) carries one transaction per item:
// opcode 0 writes key and payload at entry_index, opcode 1 searches for
// record_key over entries 0 .. entry_count-1 (entry_count clamped to the
// table depth). The table must be sorted ascending by signed key.
// Configuration channel (cfg_valid / cfg_ready, cfg_ready always high)
// writes entry_count; write it only while the block is idle.
// A write gives no result. A search of P probes (0 to 11) ends in a
// result transaction on the output channel (out_valid / out_stall);
// one probe per cycle, set by the single synchronous read port of the
// key table.
// found, position, payload_out and probe_count come from an output
// register; position and payload_out are zero when not found.
// A new item is accepted once the previous result sits in that register.
// While out_valid and out_stall are high the result holds and a finished search waits.
// Reset clears the controller, the output valid and entry_count; the
// table contents are undefined until written.
module sorted_table_binary_search import sbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [COUNT_W-1:0]       cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [0:0]               opcode,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [KEY_W-1:0]  record_key,
  input  logic [PAYLOAD_WIDTH-1:0] record_payload,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     found,
  output logic [IDX_W-1:0]         position,
  output logic [PAYLOAD_WIDTH-1:0] payload_out,
  output logic [PROBE_W-1:0]       probe_count
);

  sbs_cmd_t cmd;
  sbs_sts_t sts;

  assign cfg_ready = 1'b1;

  sbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  sbs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .entry_index    (entry_index),
    .record_key     (record_key),
    .record_payload (record_payload),
    .cmd            (cmd),
    .sts            (sts),
    .found          (found),
    .position       (position),
    .payload_out    (payload_out),
    .probe_count    (probe_count)
  );

endmodule

/* hw/rtl/sbs_checker.sv */
module sbs_checker import sbs_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     found,
  input logic [IDX_W-1:0]         position,
  input logic [PAYLOAD_WIDTH-1:0] payload_out,
  input logic [PROBE_W-1:0]       probe_count
);

  a_reset_clears_valid: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(position)
      && $stable(payload_out) && $stable(probe_count))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == '0 && payload_out == '0)
    else $error("miss with nonzero position or payload");

  a_hit_probed: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> probe_count != '0)
    else $error("hit without a probe");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> probe_count <= PROBE_W'(IDX_W + 1))
    else $error("probe count beyond search depth");

endmodule

bind sorted_table_binary_search sbs_checker u_sbs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .found       (found),
  .position    (position),
  .payload_out (payload_out),
  .probe_count (probe_count)
);
